// ===== rtl/lvrk_pkg.sv =====
// ============================================================================
// lvrk_pkg - shared types and microcode for the Lotka-Volterra RK4 stepper
// Holds the controller/datapath command types, operand codes, register
// indexes and the fixed microprogram of one RK4 step.
// ============================================================================
`default_nettype none

package lvrk_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PREY_GROWTH    = 3'd0,
    REG_PREDATION_RATE = 3'd1,
    REG_PREDATOR_DEATH = 3'd2,
    REG_PREDATOR_GAIN  = 3'd3,
    REG_PREY_START     = 3'd4,
    REG_PREDATOR_START = 3'd5,
    REG_TIME_STEP      = 3'd6,
    REG_STEP_LIMIT     = 3'd7
  } cfg_idx_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_MOV,   // dst = a
    OP_ADD,   // dst = a + b, saturating
    OP_SUB,   // dst = a - b, saturating
    OP_TADD,  // dst = a + b, unsigned saturating (time)
    OP_MUL    // dst = round(a * b / scale), saturating
  } op_t;

  // Product scaling
  typedef enum logic [1:0] {
    MUL_Q,      // divide by 2^F
    MUL_HALF,   // divide by 2^(F+1)
    MUL_SIXTH   // divide by 3 * 2^(F+1)
  } mul_mode_t;

  // Operand sources
  typedef enum logic [3:0] {
    SRC_PREY, SRC_PRED, SRC_TIME, SRC_ALPHA, SRC_BETA, SRC_GAMMA, SRC_DELTA,
    SRC_DT, SRC_XP, SRC_YP, SRC_KX, SRC_KY, SRC_AX, SRC_AY, SRC_T1, SRC_T2
  } src_t;

  // Destinations
  typedef enum logic [3:0] {
    DST_PREY, DST_PRED, DST_TIME, DST_XP, DST_YP, DST_KX, DST_KY,
    DST_AX, DST_AY, DST_T1, DST_T2
  } dst_t;

  typedef struct packed {
    op_t       op;
    mul_mode_t mode;
    src_t      a;
    src_t      b;
    dst_t      dst;
  } uop_t;

  // Controller to datapath
  typedef struct packed {
    logic restart;  // reload start values, zero time
    logic snap;     // capture current values, clear overflow
    logic start;    // begin uop
    uop_t uop;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;     // uop result written
  } dp_stat_t;

  // Controller states
  typedef enum logic [2:0] {
    C_IDLE, C_CHECK, C_ISSUE, C_WAIT, C_FINISH
  } ctrl_state_t;

  // Datapath multiply unit phases
  typedef enum logic [1:0] {
    DP_IDLE, DP_MUL, DP_ROUND, DP_DIV
  } dp_phase_t;

  localparam int PC_BITS = 6;
  localparam logic [PC_BITS-1:0] PROG_LAST = 6'd62;

  function automatic uop_t mk(op_t op, mul_mode_t mode, src_t a, src_t b, dst_t dst);
    uop_t u;
    u.op   = op;
    u.mode = mode;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    return u;
  endfunction

  // Slope evaluation at (XP, YP) into KX, KY
  function automatic uop_t slope_op(logic [2:0] i);
    uop_t u;
    unique case (i)
      3'd0:    u = mk(OP_MUL, MUL_Q, SRC_BETA,  SRC_XP, DST_T1);
      3'd1:    u = mk(OP_MUL, MUL_Q, SRC_T1,    SRC_YP, DST_T1);
      3'd2:    u = mk(OP_MUL, MUL_Q, SRC_ALPHA, SRC_XP, DST_T2);
      3'd3:    u = mk(OP_SUB, MUL_Q, SRC_T2,    SRC_T1, DST_KX);
      3'd4:    u = mk(OP_MUL, MUL_Q, SRC_DELTA, SRC_XP, DST_T1);
      3'd5:    u = mk(OP_MUL, MUL_Q, SRC_T1,    SRC_YP, DST_T1);
      3'd6:    u = mk(OP_MUL, MUL_Q, SRC_GAMMA, SRC_YP, DST_T2);
      default: u = mk(OP_SUB, MUL_Q, SRC_T1,    SRC_T2, DST_KY);
    endcase
    return u;
  endfunction

  // Microprogram of one RK4 step
  function automatic uop_t prog_op(logic [PC_BITS-1:0] pc);
    uop_t u;
    u = mk(OP_MOV, MUL_Q, SRC_T2, SRC_T2, DST_T2);
    if (pc >= 6'd2 && pc <= 6'd9) begin
      u = slope_op(3'(pc - 6'd2));
    end else if (pc >= 6'd16 && pc <= 6'd23) begin
      u = slope_op(3'(pc - 6'd16));
    end else if (pc >= 6'd32 && pc <= 6'd39) begin
      u = slope_op(3'(pc - 6'd32));
    end else if (pc >= 6'd48 && pc <= 6'd55) begin
      u = slope_op(3'(pc - 6'd48));
    end else begin
      case (pc)
        6'd0:  u = mk(OP_MOV, MUL_Q,     SRC_PREY, SRC_PREY, DST_XP);
        6'd1:  u = mk(OP_MOV, MUL_Q,     SRC_PRED, SRC_PRED, DST_YP);
        6'd10: u = mk(OP_MOV, MUL_Q,     SRC_KX,   SRC_KX,   DST_AX);
        6'd11: u = mk(OP_MOV, MUL_Q,     SRC_KY,   SRC_KY,   DST_AY);
        6'd12: u = mk(OP_MUL, MUL_HALF,  SRC_KX,   SRC_DT,   DST_T1);
        6'd13: u = mk(OP_ADD, MUL_Q,     SRC_PREY, SRC_T1,   DST_XP);
        6'd14: u = mk(OP_MUL, MUL_HALF,  SRC_KY,   SRC_DT,   DST_T1);
        6'd15: u = mk(OP_ADD, MUL_Q,     SRC_PRED, SRC_T1,   DST_YP);
        6'd24: u = mk(OP_ADD, MUL_Q,     SRC_KX,   SRC_KX,   DST_T1);
        6'd25: u = mk(OP_ADD, MUL_Q,     SRC_AX,   SRC_T1,   DST_AX);
        6'd26: u = mk(OP_ADD, MUL_Q,     SRC_KY,   SRC_KY,   DST_T1);
        6'd27: u = mk(OP_ADD, MUL_Q,     SRC_AY,   SRC_T1,   DST_AY);
        6'd28: u = mk(OP_MUL, MUL_HALF,  SRC_KX,   SRC_DT,   DST_T1);
        6'd29: u = mk(OP_ADD, MUL_Q,     SRC_PREY, SRC_T1,   DST_XP);
        6'd30: u = mk(OP_MUL, MUL_HALF,  SRC_KY,   SRC_DT,   DST_T1);
        6'd31: u = mk(OP_ADD, MUL_Q,     SRC_PRED, SRC_T1,   DST_YP);
        6'd40: u = mk(OP_ADD, MUL_Q,     SRC_KX,   SRC_KX,   DST_T1);
        6'd41: u = mk(OP_ADD, MUL_Q,     SRC_AX,   SRC_T1,   DST_AX);
        6'd42: u = mk(OP_ADD, MUL_Q,     SRC_KY,   SRC_KY,   DST_T1);
        6'd43: u = mk(OP_ADD, MUL_Q,     SRC_AY,   SRC_T1,   DST_AY);
        6'd44: u = mk(OP_MUL, MUL_Q,     SRC_KX,   SRC_DT,   DST_T1);
        6'd45: u = mk(OP_ADD, MUL_Q,     SRC_PREY, SRC_T1,   DST_XP);
        6'd46: u = mk(OP_MUL, MUL_Q,     SRC_KY,   SRC_DT,   DST_T1);
        6'd47: u = mk(OP_ADD, MUL_Q,     SRC_PRED, SRC_T1,   DST_YP);
        6'd56: u = mk(OP_ADD, MUL_Q,     SRC_AX,   SRC_KX,   DST_AX);
        6'd57: u = mk(OP_ADD, MUL_Q,     SRC_AY,   SRC_KY,   DST_AY);
        6'd58: u = mk(OP_MUL, MUL_SIXTH, SRC_AX,   SRC_DT,   DST_T1);
        6'd59: u = mk(OP_ADD, MUL_Q,     SRC_PREY, SRC_T1,   DST_PREY);
        6'd60: u = mk(OP_MUL, MUL_SIXTH, SRC_AY,   SRC_DT,   DST_T1);
        6'd61: u = mk(OP_ADD, MUL_Q,     SRC_PRED, SRC_T1,   DST_PRED);
        6'd62: u = mk(OP_TADD, MUL_Q,    SRC_TIME, SRC_DT,   DST_TIME);
        default: u = mk(OP_MOV, MUL_Q,   SRC_T2,   SRC_T2,   DST_T2);
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lvrk_dp.sv =====
// ============================================================================
// lvrk_dp - datapath of the RK4 stepper
// State and scratch registers, a saturating adder and a shared multiply unit
// (16 bits of multiplier per cycle, rounding, radix-16 divide by three).
// ============================================================================
`default_nettype none

module lvrk_dp #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lvrk_pkg::dp_cmd_t cmd,
  output lvrk_pkg::dp_stat_t     stat,
  input  wire logic [W-1:0]      alpha,
  input  wire logic [W-1:0]      beta,
  input  wire logic [W-1:0]      gamma_c,
  input  wire logic [W-1:0]      delta,
  input  wire logic [W-1:0]      dt,
  input  wire logic [W-1:0]      prey_init,
  input  wire logic [W-1:0]      pred_init,
  output logic [W-1:0]           t0,
  output logic [W-1:0]           x0,
  output logic [W-1:0]           y0,
  output logic                   ovf
);
  import lvrk_pkg::*;

  localparam int NCH  = (W + 15) / 16;
  localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int MBW  = NCH * 16;
  localparam int PW   = 2 * W + 2;
  localparam int NDIG = (W + 5) / 4;
  localparam int R3W  = NDIG * 4;
  localparam int DW   = $clog2(NDIG);
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] LIM_POS = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W - 1);

  // State and scratch registers
  logic [W-1:0] prey, pred, tim, xp, yp, kx, ky, ax, ay, t1, t2;

  // Multiply unit registers
  dp_phase_t       phase, phase_next;
  logic [W-1:0]    ma;
  logic [MBW-1:0]  mb;
  logic            neg;
  mul_mode_t       mode;
  dst_t            mdst;
  logic [PW-1:0]   prod_acc;
  logic [CNTW-1:0] cnt;
  logic [R3W-1:0]  dv;
  logic [R3W-1:0]  quo;
  logic [1:0]      rem;
  logic [DW-1:0]   dcnt;

  logic [W-1:0]    opa, opb;
  logic            wr_en, wr_sat;
  dst_t            wr_dst;
  logic [W-1:0]    wr_val;

  // Operand selection
  function automatic logic [W-1:0] pick(src_t s, logic [W-1:0] p_prey,
                                        logic [W-1:0] p_pred, logic [W-1:0] p_tim,
                                        logic [W-1:0] p_xp, logic [W-1:0] p_yp,
                                        logic [W-1:0] p_kx, logic [W-1:0] p_ky,
                                        logic [W-1:0] p_ax, logic [W-1:0] p_ay,
                                        logic [W-1:0] p_t1, logic [W-1:0] p_t2);
    logic [W-1:0] v;
    unique case (s)
      SRC_PREY:  v = p_prey;
      SRC_PRED:  v = p_pred;
      SRC_TIME:  v = p_tim;
      SRC_ALPHA: v = alpha;
      SRC_BETA:  v = beta;
      SRC_GAMMA: v = gamma_c;
      SRC_DELTA: v = delta;
      SRC_DT:    v = dt;
      SRC_XP:    v = p_xp;
      SRC_YP:    v = p_yp;
      SRC_KX:    v = p_kx;
      SRC_KY:    v = p_ky;
      SRC_AX:    v = p_ax;
      SRC_AY:    v = p_ay;
      SRC_T1:    v = p_t1;
      default:   v = p_t2;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(cmd.uop.a, prey, pred, tim, xp, yp, kx, ky, ax, ay, t1, t2);
    opb = pick(cmd.uop.b, prey, pred, tim, xp, yp, kx, ky, ax, ay, t1, t2);
  end

  // Multiply unit: product slice, rounding and divide-by-three digit step
  logic [W+15:0]  prod;
  logic [15:0]    chunk;
  logic [PW-1:0]  rnd_sum, rnd_r, lim, lim3;
  logic [W-1:0]   rnd_mag;
  logic [3:0]     digit, qd;
  logic [1:0]     rem_next;
  logic [2:0]     tmp;
  logic [R3W-1:0] quo_next;

  always_comb begin
    chunk = mb[{cnt, 4'b0} +: 16];
    prod  = (W + 16)'(ma) * (W + 16)'(chunk);

    unique case (mode)
      MUL_Q:    rnd_sum = prod_acc + (PW'(1) << (F - 1));
      MUL_HALF: rnd_sum = prod_acc + (PW'(1) << F);
      default:  rnd_sum = prod_acc + (PW'(3) << F);
    endcase
    if (mode == MUL_Q) begin
      rnd_r = rnd_sum >> F;
    end else begin
      rnd_r = rnd_sum >> (F + 1);
    end
    lim  = neg ? LIM_NEG : LIM_POS;
    lim3 = (lim << 1) + lim + PW'(2);
    rnd_mag = (rnd_r > lim) ? lim[W-1:0] : rnd_r[W-1:0];

    // Four bits of long division by three
    digit    = dv[R3W-1 -: 4];
    rem_next = rem;
    qd       = 4'b0;
    for (int j = 3; j >= 0; j--) begin
      tmp = {rem_next, digit[j]};
      if (tmp >= 3'd3) begin
        qd[j]    = 1'b1;
        rem_next = 2'(tmp - 3'd3);
      end else begin
        rem_next = tmp[1:0];
      end
    end
    quo_next = {quo[R3W-5:0], qd};
  end

  // Multiply unit phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (phase)
      DP_IDLE: begin
        if (cmd.start && cmd.uop.op == OP_MUL) phase_next = DP_MUL;
      end
      DP_MUL: begin
        if (cnt == CNTW'(NCH - 1)) phase_next = DP_ROUND;
      end
      DP_ROUND: begin
        if (mode == MUL_SIXTH && rnd_r <= lim3) phase_next = DP_DIV;
        else phase_next = DP_IDLE;
      end
      default: begin
        if (dcnt == DW'(NDIG - 1)) phase_next = DP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) phase <= DP_IDLE;
    else phase <= phase_next;
  end

  // Result write port
  logic [W:0] sum_s;
  always_comb begin
    wr_en  = 1'b0;
    wr_sat = 1'b0;
    wr_dst = cmd.uop.dst;
    wr_val = opa;
    sum_s  = '0;
    if (phase == DP_IDLE && cmd.start && cmd.uop.op != OP_MUL) begin
      wr_en = 1'b1;
      unique case (cmd.uop.op)
        OP_ADD, OP_SUB: begin
          if (cmd.uop.op == OP_ADD) sum_s = {opa[W-1], opa} + {opb[W-1], opb};
          else sum_s = {opa[W-1], opa} - {opb[W-1], opb};
          if (sum_s[W] != sum_s[W-1]) begin
            wr_sat = 1'b1;
            wr_val = sum_s[W] ? SMIN : SMAX;
          end else begin
            wr_val = sum_s[W-1:0];
          end
        end
        OP_TADD: begin
          sum_s = {1'b0, opa} + {1'b0, opb};
          wr_sat = sum_s[W];
          wr_val = sum_s[W] ? {W{1'b1}} : sum_s[W-1:0];
        end
        default: wr_val = opa;
      endcase
    end else if (phase == DP_ROUND && (mode != MUL_SIXTH || rnd_r > lim3)) begin
      wr_en  = 1'b1;
      wr_dst = mdst;
      if (mode == MUL_SIXTH) begin
        wr_sat = 1'b1;
        wr_val = neg ? (~lim[W-1:0] + W'(1)) : lim[W-1:0];
      end else begin
        wr_sat = rnd_r > lim;
        wr_val = neg ? (~rnd_mag + W'(1)) : rnd_mag;
      end
    end else if (phase == DP_DIV && dcnt == DW'(NDIG - 1)) begin
      wr_en  = 1'b1;
      wr_dst = mdst;
      wr_val = neg ? (~quo_next[W-1:0] + W'(1)) : quo_next[W-1:0];
    end
  end

  // Multiply unit data registers
  always_ff @(posedge clk) begin
    unique case (phase)
      DP_IDLE: begin
        ma       <= opa[W-1] ? (~opa + W'(1)) : opa;
        mb       <= MBW'(opb[W-1] ? (~opb + W'(1)) : opb);
        neg      <= opa[W-1] ^ opb[W-1];
        mode     <= cmd.uop.mode;
        mdst     <= cmd.uop.dst;
        prod_acc <= '0;
        cnt      <= '0;
      end
      DP_MUL: begin
        prod_acc <= prod_acc + (PW'(prod) << {cnt, 4'b0});
        cnt      <= cnt + CNTW'(1);
      end
      DP_ROUND: begin
        dv   <= rnd_r[R3W-1:0];
        quo  <= '0;
        rem  <= 2'b0;
        dcnt <= '0;
      end
      default: begin
        dv   <= dv << 4;
        quo  <= quo_next;
        rem  <= rem_next;
        dcnt <= dcnt + DW'(1);
      end
    endcase
  end

  // Register file, snapshot and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      prey <= prey_init;
      pred <= pred_init;
      tim  <= '0;
      ovf  <= 1'b0;
      stat <= '0;
    end else begin
      stat.done <= wr_en;
      if (cmd.restart) begin
        prey <= prey_init;
        pred <= pred_init;
        tim  <= '0;
      end
      if (cmd.snap) begin
        t0  <= tim;
        x0  <= prey;
        y0  <= pred;
        ovf <= 1'b0;
      end else if (wr_en && wr_sat) begin
        ovf <= 1'b1;
      end
      if (wr_en) begin
        unique case (wr_dst)
          DST_PREY: prey <= wr_val;
          DST_PRED: pred <= wr_val;
          DST_TIME: tim  <= wr_val;
          DST_XP:   xp   <= wr_val;
          DST_YP:   yp   <= wr_val;
          DST_KX:   kx   <= wr_val;
          DST_KY:   ky   <= wr_val;
          DST_AX:   ax   <= wr_val;
          DST_AY:   ay   <= wr_val;
          DST_T1:   t1   <= wr_val;
          default:  t2   <= wr_val;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lvrk_ctrl.sv =====
// ============================================================================
// lvrk_ctrl - controller of the RK4 stepper
// Accepts ticks, tracks the step count, walks the microprogram one uop at a
// time and hands finished results to the output register.
// ============================================================================
`default_nettype none

module lvrk_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               restart,
  input  wire logic [15:0]        step_limit,
  input  wire logic               out_free,
  output logic                    out_load,
  output logic                    last,
  output lvrk_pkg::dp_cmd_t       cmd,
  input  wire lvrk_pkg::dp_stat_t stat
);
  import lvrk_pkg::*;

  ctrl_state_t          state, state_next;
  logic [PC_BITS-1:0]   pc, pc_next;
  logic [15:0]          steps, steps_next;
  logic [16:0]          steps_inc;

  assign steps_inc = {1'b0, steps} + 17'd1;
  assign last      = (steps_inc == {1'b0, step_limit});

  // Next state and outputs
  always_comb begin
    state_next   = state;
    pc_next      = pc;
    steps_next   = steps;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    cmd.restart  = 1'b0;
    cmd.snap     = 1'b0;
    cmd.start    = 1'b0;
    cmd.uop      = prog_op(pc);
    unique case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.restart = restart;
          if (restart) steps_next = '0;
          state_next = C_CHECK;
        end
      end
      C_CHECK: begin
        if (steps >= step_limit) begin
          state_next = C_IDLE;
        end else begin
          cmd.snap   = 1'b1;
          pc_next    = '0;
          state_next = C_ISSUE;
        end
      end
      C_ISSUE: begin
        cmd.start  = 1'b1;
        state_next = C_WAIT;
      end
      C_WAIT: begin
        if (stat.done) begin
          if (pc == PROG_LAST) begin
            state_next = C_FINISH;
          end else begin
            pc_next    = pc + PC_BITS'(1);
            state_next = C_ISSUE;
          end
        end
      end
      default: begin
        if (out_free) begin
          out_load   = 1'b1;
          steps_next = steps_inc[15:0];
          state_next = C_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      pc    <= '0;
      steps <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      steps <= steps_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lotka_volterra_rk4_stepper.sv =====
// ============================================================================
// lotka_volterra_rk4_stepper - predator-prey RK4 integrator, fixed point
// Configuration registers, output register and the controller/datapath pair.
// ============================================================================
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+------------------------
//  in      | in_valid/in_ready, restart       | in_valid && in_ready
//  out     | out_valid/out_ready, 5 fields    | out_valid && out_ready
//  cfg     | cfg_valid/cfg_ready, index, data | cfg_valid && cfg_ready
//
//  A tick that yields a result runs 63 uops in sequence, 32 of them
//  products through the one shared multiply unit (16 multiplier bits per
//  cycle), two with a radix-16 divide by three that is skipped when a
//  final dt/6 product saturates. A tick past the step limit yields no
//  result. Reset loads register defaults and the start values. The next
//  tick is taken while a result waits in the output register; only the
//  final hand-off waits on out_ready.
//
`default_nettype none

module lotka_volterra_rk4_stepper #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         restart,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       sim_time,
  output logic signed [31:0] prey_level,
  output logic signed [31:0] predator_level,
  output logic              last_step,
  output logic              overflow,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import lvrk_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [32:0] SMAX33 =
    (W >= 33) ? 33'sd0 : ((33'sd1 <<< (W - 1)) - 33'sd1);
  localparam logic signed [32:0] SMIN33 = -SMAX33 - 33'sd1;

  // Fit a 33-bit signed value to the word, clamping when the word is narrower
  function automatic logic [W-1:0] fit_word(logic [32:0] v);
    logic signed [32:0] sv;
    logic [W-1:0]       res;
    sv = signed'(v);
    if (W >= 33) res = W'(sv);
    else if (sv > SMAX33) res = SMAX;
    else if (sv < SMIN33) res = SMIN;
    else res = W'(sv);
    return res;
  endfunction

  // Configuration registers
  logic [W-1:0] alpha, beta, gamma_c, delta, prey_init, pred_init, dt;
  logic [15:0]  step_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= fit_word(33'd65536);
      beta       <= fit_word(33'd6554);
      gamma_c    <= fit_word(33'd98304);
      delta      <= fit_word(33'd4915);
      prey_init  <= fit_word(33'd655360);
      pred_init  <= fit_word(33'd327680);
      dt         <= fit_word(33'd655);
      step_limit <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PREY_GROWTH:    alpha     <= fit_word({cfg_data[31], cfg_data});
        REG_PREDATION_RATE: beta      <= fit_word({cfg_data[31], cfg_data});
        REG_PREDATOR_DEATH: gamma_c   <= fit_word({cfg_data[31], cfg_data});
        REG_PREDATOR_GAIN:  delta     <= fit_word({cfg_data[31], cfg_data});
        REG_PREY_START:     prey_init <= fit_word({cfg_data[31], cfg_data});
        REG_PREDATOR_START: pred_init <= fit_word({cfg_data[31], cfg_data});
        REG_TIME_STEP:      dt        <= fit_word({2'b00, cfg_data[30:0]});
        default:            step_limit <= cfg_data[15:0];
      endcase
    end
  end

  // Controller and datapath
  dp_cmd_t      cmd;
  dp_stat_t     stat;
  logic         out_load, last, out_free, ovf;
  logic [W-1:0] t0, x0, y0;

  assign out_free = !out_valid || out_ready;

  lvrk_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .step_limit (step_limit),
    .out_free   (out_free),
    .out_load   (out_load),
    .last       (last),
    .cmd        (cmd),
    .stat       (stat)
  );

  lvrk_dp #(.W(W), .F(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .alpha     (alpha),
    .beta      (beta),
    .gamma_c   (gamma_c),
    .delta     (delta),
    .dt        (dt),
    .prey_init (prey_init),
    .pred_init (pred_init),
    .t0        (t0),
    .x0        (x0),
    .y0        (y0),
    .ovf       (ovf)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sim_time       <= 32'(t0);
      prey_level     <= 32'(signed'(x0));
      predator_level <= 32'(signed'(y0));
      last_step      <= last;
      overflow       <= ovf;
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ============================================================================
// Lotka-Volterra RK4 stepper testbench
// Drives restart ticks and register writes into the stepper, predicts each
// result with a fixed-point RK4 model of its own and compares field by field.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
  import lvrk_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int     IDLE_GAP = 300;
  localparam int     WATCH_LIMIT = 20000;

  // Expected result of one tick
  typedef struct {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic        fin;
    logic        ovf;
  } lv_sample_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: fixed-point RK4 predictor plus expected-sample queue
  // ---------------------------------------------------------------------------
  class lv_scoreboard;
    longint      coef [8];
    longint      t_now, x_now, y_now;
    int unsigned steps;
    bit          sat;
    lv_sample_t  pending [$];
    int          errors;
    int          checked;
    int          finals;
    int          sats;

    function void set_reg(int idx, logic [31:0] v);
      if (idx == REG_STEP_LIMIT) coef[idx] = v[15:0];
      else if (idx == REG_TIME_STEP) coef[idx] = v[30:0];
      else coef[idx] = longint'($signed(v));
    endfunction

    function void reload();
      t_now = 0;
      x_now = coef[REG_PREY_START];
      y_now = coef[REG_PREDATOR_START];
      steps = 0;
    endfunction

    function void init();
      set_reg(REG_PREY_GROWTH, 65536);
      set_reg(REG_PREDATION_RATE, 6554);
      set_reg(REG_PREDATOR_DEATH, 98304);
      set_reg(REG_PREDATOR_GAIN, 4915);
      set_reg(REG_PREY_START, 655360);
      set_reg(REG_PREDATOR_START, 327680);
      set_reg(REG_TIME_STEP, 655);
      set_reg(REG_STEP_LIMIT, 1000);
      reload();
    endfunction

    function longint clip(longint v);
      if (v > WMAX) begin
        sat = 1;
        return WMAX;
      end
      if (v < WMIN) begin
        sat = 1;
        return WMIN;
      end
      return v;
    endfunction

    // round(a*b / (2^sh * div)), half away from zero, then saturate
    function longint prod(longint a, longint b, int sh, int div);
      logic signed [127:0] p;
      logic [127:0] m;
      bit neg;
      neg = (a < 0) != (b < 0);
      p = 128'(a) * 128'(b);
      m = p < 0 ? 128'(-p) : 128'(p);
      m = (m + ((128'(1) << (sh - 1)) * div)) / div;
      m = m >> sh;
      if (m > 128'(WMAX) + (neg ? 1 : 0)) begin
        sat = 1;
        m = 128'(WMAX) + (neg ? 1 : 0);
      end
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function void slope(longint x, longint y, output longint fx, output longint fy);
      longint bx, dx;
      bx = prod(prod(coef[REG_PREDATION_RATE], x, 16, 1), y, 16, 1);
      dx = prod(prod(coef[REG_PREDATOR_GAIN], x, 16, 1), y, 16, 1);
      fx = clip(prod(coef[REG_PREY_GROWTH], x, 16, 1) - bx);
      fy = clip(dx - prod(coef[REG_PREDATOR_DEATH], y, 16, 1));
    endfunction

    function longint blend(longint k1, longint k2, longint k3, longint k4);
      longint s;
      s = clip(k1 + clip(k2 + k2));
      s = clip(s + clip(k3 + k3));
      return clip(s + k4);
    endfunction

    function void advance();
      longint dt, k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y;
      dt = coef[REG_TIME_STEP];
      slope(x_now, y_now, k1x, k1y);
      slope(clip(x_now + prod(k1x, dt, 17, 1)), clip(y_now + prod(k1y, dt, 17, 1)),
            k2x, k2y);
      slope(clip(x_now + prod(k2x, dt, 17, 1)), clip(y_now + prod(k2y, dt, 17, 1)),
            k3x, k3y);
      slope(clip(x_now + prod(k3x, dt, 16, 1)), clip(y_now + prod(k3y, dt, 16, 1)),
            k4x, k4y);
      x_now = clip(x_now + prod(blend(k1x, k2x, k3x, k4x), dt, 17, 3));
      y_now = clip(y_now + prod(blend(k1y, k2y, k3y, k4y), dt, 17, 3));
      t_now = t_now + dt;
      if (t_now > 64'hFFFF_FFFF) begin
        sat = 1;
        t_now = 64'hFFFF_FFFF;
      end
    endfunction

    // Accepted tick: predict its result, if any
    function void note_tick(bit rs);
      lv_sample_t e;
      if (rs) reload();
      if (steps >= coef[REG_STEP_LIMIT]) return;
      e.t = t_now[31:0];
      e.x = x_now[31:0];
      e.y = y_now[31:0];
      sat = 0;
      advance();
      steps++;
      e.fin = (steps == coef[REG_STEP_LIMIT]);
      e.ovf = sat;
      pending = {pending, e};
    endfunction

    // One line per mismatch, counted
    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(lv_sample_t got);
      lv_sample_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.fin) finals++;
      if (got.ovf) sats++;
      if (got.t !== e.t) report_mismatch("sim_time", got.t, e.t);
      if (got.x !== e.x) report_mismatch("prey_level", got.x, e.x);
      if (got.y !== e.y) report_mismatch("predator_level", got.y, e.y);
      if (got.fin !== e.fin) report_mismatch("last_step", got.fin, e.fin);
      if (got.ovf !== e.ovf) report_mismatch("overflow", got.ovf, e.ovf);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        restart = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] sim_time;
  logic signed [31:0] prey_level;
  logic signed [31:0] predator_level;
  logic        last_step;
  logic        overflow;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  lv_scoreboard sb;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          quiet = 0;
  int          ticks = 0;

  always #6 clk = ~clk;

  lotka_volterra_rk4_stepper u_top (.*);

  // Receiver: random stalls, sample results at the edge
  always @(posedge clk) begin
    lv_sample_t r;
    if (!rst && out_valid && out_ready) begin
      r.t = sim_time;
      r.x = prey_level;
      r.y = predator_level;
      r.fin = last_step;
      r.ovf = overflow;
      sb.check(r);
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WATCH_LIMIT) begin
      $display("watchdog expired");
      $display("lotka_volterra_rk4_stepper verification failed");
      $finish;
    end
  end

  // Valid stays up between ticks unless the sender idles; drain drops it
  task automatic tick(bit rs);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(rs);
    ticks++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_model(logic [31:0] a, logic [31:0] b, logic [31:0] g, logic [31:0] d,
                           logic [31:0] x0, logic [31:0] y0, logic [31:0] dt,
                           logic [31:0] lim);
    write_reg(REG_PREY_GROWTH, a);
    write_reg(REG_PREDATION_RATE, b);
    write_reg(REG_PREDATOR_DEATH, g);
    write_reg(REG_PREDATOR_GAIN, d);
    write_reg(REG_PREY_START, x0);
    write_reg(REG_PREDATOR_START, y0);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_STEP_LIMIT, lim);
  endtask

  // A run: restart then continue ticks, with a few stray restarts
  task automatic run_ticks(int n);
    tick(1);
    for (int i = 1; i < n; i++) tick($urandom_range(19) == 0);
  endtask

  task automatic random_phase(int n);
    set_model($urandom_range(131072), $urandom_range(13107), $urandom_range(131072),
              $urandom_range(13107), $urandom_range(1310720), $urandom_range(655360),
              $urandom_range(6553), $urandom_range(40, 3));
    run_ticks(n);
    drain();
    // extreme registers: random bits everywhere but the step limit
    set_model($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(12));
    run_ticks(n / 4);
    drain();
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset values, run end, zero limit, extreme registers, limit raised and lowered mid-run
    tick(0);
    tick(0);
    tick(1);
    drain();
    write_reg(REG_STEP_LIMIT, 3);
    tick(1); tick(0); tick(0); tick(0); tick(0);
    drain();
    write_reg(REG_STEP_LIMIT, 0);
    tick(1); tick(0);
    drain();
    set_model(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    tick(1); tick(0); tick(0);
    drain();
    set_model(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6);
    tick(1); tick(0); tick(0);
    drain();
    set_model(0, 0, 0, 0, 0, 0, 0, 4);
    tick(1); tick(0);
    drain();
    write_reg(REG_STEP_LIMIT, 8);
    tick(0); tick(0); tick(0);
    drain();
    write_reg(REG_STEP_LIMIT, 1);
    tick(0);
    drain();

    // Random phases under three idle patterns
    send_idle = 18; recv_idle = 59;
    random_phase(130);
    random_phase(130);
    send_idle = 59; recv_idle = 18;
    random_phase(130);
    random_phase(130);
    send_idle = 0; recv_idle = 0;
    random_phase(130);
    random_phase(130);
    drain();

    $display("Ran %0d ticks, checked %0d results (%0d run ends, %0d saturating).",
             ticks, sb.checked, sb.finals, sb.sats);
    if (sb.errors == 0)
      $display("lotka_volterra_rk4_stepper verification clean");
    else
      $display("lotka_volterra_rk4_stepper verification failed");
    $finish;
  end
endmodule
